/* rtl/core/sapsl_pkg.sv */
// Package for the servo angle-to-pulse slew limiter.
// Holds command codes, register indexes, reset values and the
// controller/datapath interface structs. Depends on nothing.
package sapsl_pkg;

  // Field widths
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned WIDE_W  = 20;

  // Restoring divider: one quotient bit per step over the full product
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ANGLE   = 2'd0,
    CMD_PULSE   = 2'd1,
    CMD_NEUTRAL = 2'd2
  } cmd_t;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_MIN_PULSE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_PULSE = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_PULSE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_ANGLE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_STEP     = 3'd4;

  // Reset values
  localparam logic [PULSE_W-1:0] RST_MIN_PULSE    = 16'd1000;
  localparam logic [PULSE_W-1:0] RST_CENTER_PULSE = 16'd1500;
  localparam logic [PULSE_W-1:0] RST_MAX_PULSE    = 16'd2000;
  localparam logic [LIMIT_W-1:0] RST_MAX_ANGLE    = 15'd1000;
  localparam logic [PULSE_W-1:0] RST_MAX_STEP     = 16'd50;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic mult;      // form the product magnitude, clear the remainder
    logic div_step;  // one restoring division step
    logic slew;      // build the target and apply the step limit
    logic commit;    // clamp, update the held pulse, load the result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // accepted angle command with a nonzero full scale
  } dp_stat_t;

endpackage

/* rtl/core/sapsl_ctrl.sv */
// Controller for the servo angle-to-pulse slew limiter.
// Sequences capture, multiply, serial divide, slew and commit.
// Depends on sapsl_pkg.
module sapsl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sapsl_pkg::dp_stat_t stat,
  output sapsl_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_SLEW,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [sapsl_pkg::DIV_CNT_W-1:0] div_count;
  logic                            div_last;
  logic                            slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign div_last  = (div_count == sapsl_pkg::DIV_CNT_W'(sapsl_pkg::DIV_STEPS - 1));
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state == ST_IDLE) && in_valid;
    cmd_o.mult     = (state == ST_MULT);
    cmd_o.div_step = (state == ST_DIV);
    cmd_o.slew     = (state == ST_SLEW);
    cmd_o.commit   = (state == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MULT;
          end
        end
        ST_MULT: begin
          div_count <= '0;
          state     <= stat.need_div ? ST_DIV : ST_SLEW;
        end
        ST_DIV: begin
          div_count <= div_count + 1'b1;
          if (div_last) begin
            state <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register can take the result
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/sapsl_dp.sv */
// Datapath for the servo angle-to-pulse slew limiter.
// Config registers, held pulse, multiplier, serial divider, slew and clamp.
// Depends on sapsl_pkg.
module sapsl_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sapsl_pkg::IDX_W-1:0]           cfg_index,
  input  logic [sapsl_pkg::PULSE_W-1:0]         cfg_data,
  input  logic [sapsl_pkg::CMD_W-1:0]           cmd,
  input  logic signed [sapsl_pkg::ANGLE_W-1:0]  steer_angle,
  input  logic [sapsl_pkg::PULSE_W-1:0]         pulse_request,
  output logic                                  accepted,
  output logic [sapsl_pkg::PULSE_W-1:0]         pulse_now,
  input  sapsl_pkg::dp_cmd_t                    ctl,
  output sapsl_pkg::dp_stat_t                   stat
);

  localparam int unsigned PW = sapsl_pkg::PULSE_W;
  localparam int unsigned AW = sapsl_pkg::ANGLE_W;
  localparam int unsigned LW = sapsl_pkg::LIMIT_W;
  localparam int unsigned XW = sapsl_pkg::PROD_W;
  localparam int unsigned WW = sapsl_pkg::WIDE_W;

  // Configuration and state
  logic [PW-1:0] min_pulse;
  logic [PW-1:0] center_pulse;
  logic [PW-1:0] max_pulse;
  logic [LW-1:0] max_angle;
  logic [PW-1:0] max_step;
  logic [PW-1:0] held_pulse;

  // Captured transaction
  sapsl_pkg::cmd_t cmd_q;
  logic            ok_q;
  logic            neg_q;
  logic [AW-1:0]   angle_mag_q;
  logic [PW-1:0]   diff_mag_q;
  logic [PW-1:0]   preq_q;

  // Divider
  logic [XW-1:0]   dvd;
  logic [LW-1:0]   rem;
  logic [LW:0]     shifted;
  logic [LW:0]     divisor;
  logic [LW:0]     rem_sub;
  logic            fits;

  // Capture-time logic
  logic            angle_neg;
  logic [AW-1:0]   angle_mag;
  logic [PW:0]     diff;
  logic [PW:0]     diff_abs;
  logic signed [AW:0] angle_ext;
  logic signed [AW:0] lim;
  logic            in_env;
  logic            ok_in;

  // Slew and clamp
  logic [PW-1:0]          q_mag;
  logic signed [WW-1:0]   q_w;
  logic signed [WW-1:0]   target;
  logic signed [WW-1:0]   h_hi;
  logic signed [WW-1:0]   h_lo;
  logic signed [WW-1:0]   slewed;
  logic signed [WW-1:0]   wide_q;
  logic signed [WW-1:0]   min_w;
  logic signed [WW-1:0]   max_w;
  logic [PW-1:0]          clamped;

  assign angle_neg = steer_angle[AW-1];
  assign angle_mag = angle_neg ? (~steer_angle + 1'b1) : steer_angle;
  assign diff      = {1'b0, max_pulse} - {1'b0, center_pulse};
  assign diff_abs  = diff[PW] ? (~diff + 1'b1) : diff;
  assign angle_ext = {steer_angle[AW-1], steer_angle};
  assign lim       = $signed({{(AW + 1 - LW){1'b0}}, max_angle});
  assign in_env    = (angle_ext <= lim) && (angle_ext >= -lim);

  always_comb begin
    case (cmd)
      sapsl_pkg::CMD_ANGLE:   ok_in = in_env;
      sapsl_pkg::CMD_PULSE:   ok_in = 1'b1;
      sapsl_pkg::CMD_NEUTRAL: ok_in = 1'b1;
      default:                ok_in = 1'b0;
    endcase
  end

  assign stat.need_div = (cmd_q == sapsl_pkg::CMD_ANGLE) && ok_q && (max_angle != '0);

  // Restoring division step
  assign shifted = {rem, dvd[XW-1]};
  assign divisor = {1'b0, max_angle};
  assign fits    = (shifted >= divisor);
  assign rem_sub = shifted - divisor;

  // Target, step limit and clamp
  assign q_mag  = (max_angle == '0) ? '0 : dvd[PW-1:0];
  assign q_w    = neg_q ? -$signed({{(WW - PW){1'b0}}, q_mag})
                        : $signed({{(WW - PW){1'b0}}, q_mag});
  assign target = $signed({{(WW - PW){1'b0}}, center_pulse}) + q_w;
  assign h_hi   = $signed({{(WW - PW){1'b0}}, held_pulse})
                + $signed({{(WW - PW){1'b0}}, max_step});
  assign h_lo   = $signed({{(WW - PW){1'b0}}, held_pulse})
                - $signed({{(WW - PW){1'b0}}, max_step});

  always_comb begin
    if (target > h_hi) begin
      slewed = h_hi;
    end else if (target < h_lo) begin
      slewed = h_lo;
    end else begin
      slewed = target;
    end
  end

  assign min_w = $signed({{(WW - PW){1'b0}}, min_pulse});
  assign max_w = $signed({{(WW - PW){1'b0}}, max_pulse});

  always_comb begin
    if (wide_q < min_w) begin
      clamped = min_pulse;
    end else if (wide_q > max_w) begin
      clamped = max_pulse;
    end else begin
      clamped = wide_q[PW-1:0];
    end
  end

  // Config registers and held pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse    <= sapsl_pkg::RST_MIN_PULSE;
      center_pulse <= sapsl_pkg::RST_CENTER_PULSE;
      max_pulse    <= sapsl_pkg::RST_MAX_PULSE;
      max_angle    <= sapsl_pkg::RST_MAX_ANGLE;
      max_step     <= sapsl_pkg::RST_MAX_STEP;
      held_pulse   <= sapsl_pkg::RST_CENTER_PULSE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sapsl_pkg::REG_MIN_PULSE:    min_pulse    <= cfg_data;
          sapsl_pkg::REG_CENTER_PULSE: center_pulse <= cfg_data;
          sapsl_pkg::REG_MAX_PULSE:    max_pulse    <= cfg_data;
          sapsl_pkg::REG_MAX_ANGLE:    max_angle    <= cfg_data[LW-1:0];
          sapsl_pkg::REG_MAX_STEP:     max_step     <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.commit && ok_q) begin
        held_pulse <= clamped;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q       <= sapsl_pkg::cmd_t'(cmd);
      ok_q        <= ok_in;
      neg_q       <= angle_neg ^ diff[PW];
      angle_mag_q <= angle_mag;
      diff_mag_q  <= diff_abs[PW-1:0];
      preq_q      <= pulse_request;
    end
    if (ctl.mult) begin
      dvd <= {{(XW - AW){1'b0}}, angle_mag_q} * {{(XW - PW){1'b0}}, diff_mag_q};
      rem <= '0;
    end else if (ctl.div_step) begin
      dvd <= {dvd[XW-2:0], fits};
      rem <= fits ? rem_sub[LW-1:0] : shifted[LW-1:0];
    end
    if (ctl.slew) begin
      case (cmd_q)
        sapsl_pkg::CMD_ANGLE: wide_q <= slewed;
        sapsl_pkg::CMD_PULSE: wide_q <= $signed({{(WW - PW){1'b0}}, preq_q});
        default:              wide_q <= $signed({{(WW - PW){1'b0}}, center_pulse});
      endcase
    end
    if (ctl.commit) begin
      accepted  <= ok_q;
      pulse_now <= ok_q ? clamped : held_pulse;
    end
  end

endmodule

/* rtl/core/servo_angle_to_pulse_slew_limiter.sv */
// Top level of the servo angle-to-pulse slew limiter.
// Joins the controller and the datapath. Depends on sapsl_pkg,
// sapsl_ctrl and sapsl_dp.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   cmd, steer_angle, pulse_request
//   out      output     out_valid / out_stall accepted, pulse_now
//   cfg      input      cfg_we (no wait)      cfg_index, cfg_data
//
// An accepted angle command with nonzero max_angle passes through a multiply
// step, the bit-serial restoring divider by max_angle, a slew step and a
// commit step. Every other transaction skips the divider. in_stall drops in
// the cycle after the commit, so a new transaction is taken only once the
// previous one has committed.
// A commit holds while the output register is stalled; rst loads reset values.
module servo_angle_to_pulse_slew_limiter (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [sapsl_pkg::IDX_W-1:0]           cfg_index,
  input  logic [sapsl_pkg::PULSE_W-1:0]         cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sapsl_pkg::CMD_W-1:0]           cmd,
  input  logic signed [sapsl_pkg::ANGLE_W-1:0]  steer_angle,
  input  logic [sapsl_pkg::PULSE_W-1:0]         pulse_request,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  accepted,
  output logic [sapsl_pkg::PULSE_W-1:0]         pulse_now
);

  sapsl_pkg::dp_cmd_t  dp_cmd;
  sapsl_pkg::dp_stat_t dp_stat;

  // Sequencer: capture on acceptance, then multiply, divide, slew, commit
  sapsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd_o     (dp_cmd)
  );

  // Arithmetic, config registers, held pulse and result registers
  sapsl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .steer_angle   (steer_angle),
    .pulse_request (pulse_request),
    .accepted      (accepted),
    .pulse_now     (pulse_now),
    .ctl           (dp_cmd),
    .stat          (dp_stat)
  );

endmodule
